[src/robin_hood_hash_table_core_defines.svh]
// Assertion macros used by the hash table controller
`ifndef ROBIN_HOOD_HASH_TABLE_CORE_DEFINES_SVH
`define ROBIN_HOOD_HASH_TABLE_CORE_DEFINES_SVH

// Implication checked at each rising clock edge, off while reset is high
`define RHH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, also active during reset
`define RHH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/rhh_pkg.sv]
// Shared types and constants for the Robin Hood hash table
package rhh_pkg;
   localparam int SLOTS = 64;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = IDX_W + 1;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int KEY_BYTES = 4;
   localparam int BYTE_CNT_W = 2;
   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
   localparam logic [6:0] LIMIT_RESET = 7'd48;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [KEY_W-1:0] key_type;
   typedef logic [VAL_W-1:0] val_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_FOUND    = 3'd2,
      ST_MISSING  = 3'd3,
      ST_REMOVED  = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_HASH_X, S_HASH_M0, S_HASH_M1, S_HASH_M2,
      S_FIND_RD, S_FIND_CHK, S_PLACE_RD, S_PLACE_CHK,
      S_DROP_RD, S_DROP_CHK, S_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } hash_ctl_type;
endpackage

[src/rhh_if.sv]
// Valid/ready channel interfaces for requests and responses
interface rhh_req_if;
   import rhh_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] op;
   key_type key;
   val_type value;
   modport source (output valid, op, key, value, input ready);
   modport sink (input valid, op, key, value, output ready);
endinterface

interface rhh_rsp_if;
   import rhh_pkg::*;
   logic valid;
   logic ready;
   logic [2:0] status;
   val_type found_value;
   cnt_type entry_count;
   modport source (output valid, status, found_value, entry_count, input ready);
   modport sink (input valid, status, found_value, entry_count, output ready);
endinterface

[src/rhh_hash.sv]
// Iterative FNV-1a hash: one byte per pass, h times the low part of the prime in four 16-bit slices
module rhh_hash (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  rhh_pkg::key_type key,
   output logic busy,
   output logic done,
   output rhh_pkg::idx_type home
);
   import rhh_pkg::*;

   // only the low 64 bits of h*prime matter; prime = 2^40 + 0x1b3
   // h*prime = (h << 40) + h*0x1b3 ; h*0x1b3 done as four 16-bit slices
   logic [63:0] h_ff, h_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0] slice_ff, slice_in;
   logic [BYTE_CNT_W-1:0] byte_ff, byte_in;
   logic mul_ff, mul_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [15:0] hpart;
   logic [63:0] prod;

   always_comb begin
      hpart = h_ff[16*slice_ff +: 16];
      prod = 64'(({48'd0, hpart} * 64'h1b3) << (16 * slice_ff));
   end

   always_comb begin
      h_in = h_ff;
      acc_in = acc_ff;
      slice_in = slice_ff;
      byte_in = byte_ff;
      mul_in = mul_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         h_in = FNV_BASIS;
         byte_in = '0;
         mul_in = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!mul_ff) begin
            h_in = h_ff ^ {56'd0, key[8*byte_ff +: 8]};
            acc_in = (h_ff ^ {56'd0, key[8*byte_ff +: 8]}) << 40;
            slice_in = '0;
            mul_in = 1'b1;
         end else begin
            acc_in = acc_ff + prod;
            slice_in = slice_ff + 2'd1;
            if (slice_ff == 2'd3) begin
               h_in = acc_ff + prod;
               mul_in = 1'b0;
               byte_in = byte_ff + 1'b1;
               if (byte_ff == BYTE_CNT_W'(KEY_BYTES - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      acc_ff <= acc_in;
      slice_ff <= slice_in;
      byte_ff <= byte_in;
      mul_ff <= mul_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign home = h_ff[IDX_W-1:0];
endmodule

[src/rhh_store.sv]
// Slot memories: key/value/distance RAM plus used flops, registered reads
module rhh_store (
   input  logic clock,
   input  logic reset,
   input  rhh_pkg::idx_type rd_idx,
   output rhh_pkg::key_type rd_key,
   output rhh_pkg::val_type rd_val,
   output logic rd_used,
   output rhh_pkg::idx_type rd_dist,
   input  logic wr_en,
   input  rhh_pkg::idx_type wr_idx,
   input  logic wr_kv,
   input  rhh_pkg::key_type wr_key,
   input  rhh_pkg::val_type wr_val,
   input  logic wr_used,
   input  rhh_pkg::idx_type wr_dist
);
   import rhh_pkg::*;

   key_type key_mem [SLOTS];
   val_type val_mem [SLOTS];
   logic [SLOTS-1:0] used_ff;
   // distance is only looked at for used slots, so it needs no reset
   idx_type dist_mem [SLOTS];
   key_type rkey_ff;
   val_type rval_ff;
   logic rused_ff;
   idx_type rdist_ff;

   always_ff @(posedge clock) begin
      if (wr_en && wr_kv) begin
         key_mem[wr_idx] <= wr_key;
         val_mem[wr_idx] <= wr_val;
      end
      if (wr_en) dist_mem[wr_idx] <= wr_dist;
      rkey_ff <= key_mem[rd_idx];
      rval_ff <= val_mem[rd_idx];
      rused_ff <= used_ff[rd_idx];
      rdist_ff <= dist_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr_en) begin
         used_ff[wr_idx] <= wr_used;
      end
   end

   assign rd_key = rkey_ff;
   assign rd_val = rval_ff;
   assign rd_used = rused_ff;
   assign rd_dist = rdist_ff;
endmodule

[src/rhh_ctrl.sv]
// Request sequencer: hash, probe, displacing insert, backward-shift remove
`include "robin_hood_hash_table_core_defines.svh"
module rhh_ctrl (
   input  logic clock,
   input  logic reset,
   rhh_req_if.sink req,
   rhh_rsp_if.source rsp,
   input  logic [6:0] limit,
   output rhh_pkg::hash_ctl_type hctl,
   output rhh_pkg::key_type hkey,
   input  rhh_pkg::idx_type home,
   output rhh_pkg::idx_type rd_idx,
   input  rhh_pkg::key_type rd_key,
   input  rhh_pkg::val_type rd_val,
   input  logic rd_used,
   input  rhh_pkg::idx_type rd_dist,
   output logic wr_en,
   output rhh_pkg::idx_type wr_idx,
   output logic wr_kv,
   output rhh_pkg::key_type wr_key,
   output rhh_pkg::val_type wr_val,
   output logic wr_used,
   output rhh_pkg::idx_type wr_dist,
   input  logic hash_busy,
   input  logic hash_done
);
   import rhh_pkg::*;

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   key_type key_ff, key_in;
   val_type val_ff, val_in;
   idx_type idx_ff, idx_in;
   logic [CNT_W-1:0] dist_ff, dist_in;   // one wider so a full walk ends
   cnt_type cnt_ff, cnt_in;
   logic [2:0] status_ff, status_in;
   val_type vout_ff, vout_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] lim_eff;
   idx_type nxt;

   assign nxt = idx_ff + 1'b1;
   assign lim_eff = (limit > 7'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(limit);

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      key_ff <= key_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      dist_ff <= dist_in;
      status_ff <= status_in;
      vout_ff <= vout_in;
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      key_in = key_ff;
      val_in = val_ff;
      idx_in = idx_ff;
      dist_in = dist_ff;
      cnt_in = cnt_ff;
      status_in = status_ff;
      vout_in = vout_ff;
      rsp_valid_in = rsp_valid_ff;
      hctl = '0;
      rd_idx = idx_ff;
      wr_en = 1'b0;
      wr_idx = idx_ff;
      wr_kv = 1'b0;
      wr_key = key_ff;
      wr_val = val_ff;
      wr_used = 1'b1;
      wr_dist = dist_ff[IDX_W-1:0];
      req.ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in = op_type'(req.op);
               key_in = req.key;
               val_in = req.value;
               hctl.start = 1'b1;
               state_in = S_HASH_X;
            end
         end
         S_HASH_X, S_HASH_M0, S_HASH_M1, S_HASH_M2: begin
            if (hash_done) begin
               idx_in = home;
               dist_in = '0;
               state_in = S_FIND_RD;
            end
         end
         S_FIND_RD: state_in = S_FIND_CHK;
         S_FIND_CHK: begin
            if (!rd_used || dist_ff > CNT_W'(rd_dist) || dist_ff == CNT_W'(SLOTS)) begin
               // key absent
               status_in = ST_MISSING;
               vout_in = '0;
               state_in = S_DONE;
               if (op_ff == OP_INSERT) begin
                  if (cnt_ff + 1'b1 > lim_eff) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in = ST_INSERTED;
                     cnt_in = cnt_ff + 1'b1;
                     idx_in = home;
                     dist_in = '0;
                     state_in = S_PLACE_RD;
                  end
               end
            end else if (rd_key == key_ff) begin
               state_in = S_DONE;
               vout_in = '0;
               case (op_ff)
                  OP_INSERT: begin
                     wr_en = 1'b1;
                     wr_kv = 1'b1;
                     wr_key = rd_key;
                     wr_dist = rd_dist;
                     status_in = ST_UPDATED;
                  end
                  OP_LOOKUP: begin
                     status_in = ST_FOUND;
                     vout_in = rd_val;
                  end
                  OP_REMOVE: begin
                     wr_en = 1'b1;
                     wr_used = 1'b0;
                     wr_dist = '0;
                     status_in = ST_REMOVED;
                     cnt_in = cnt_ff - 1'b1;
                     state_in = S_DROP_RD;
                  end
                  default: status_in = ST_MISSING;
               endcase
            end else begin
               idx_in = nxt;
               dist_in = dist_ff + 1'b1;
               state_in = S_FIND_RD;
            end
         end
         S_PLACE_RD: state_in = S_PLACE_CHK;
         S_PLACE_CHK: begin
            if (!rd_used) begin
               wr_en = 1'b1;
               wr_kv = 1'b1;
               state_in = S_DONE;
            end else begin
               if (CNT_W'(rd_dist) < dist_ff) begin
                  wr_en = 1'b1;
                  wr_kv = 1'b1;
                  key_in = rd_key;
                  val_in = rd_val;
                  dist_in = CNT_W'(rd_dist) + 1'b1;
               end else begin
                  dist_in = dist_ff + 1'b1;
               end
               idx_in = nxt;
               state_in = S_PLACE_RD;
            end
         end
         S_DROP_RD: begin
            // slot idx is the hole: free it while reading the one after
            wr_en = 1'b1;
            wr_used = 1'b0;
            wr_dist = '0;
            rd_idx = nxt;
            state_in = S_DROP_CHK;
         end
         S_DROP_CHK: begin
            // rd_* holds slot idx+1; pull it back into the hole
            if (!rd_used || rd_dist == '0) begin
               state_in = S_DONE;
            end else begin
               wr_en = 1'b1;
               wr_kv = 1'b1;
               wr_key = rd_key;
               wr_val = rd_val;
               wr_dist = rd_dist - 1'b1;
               idx_in = nxt;
               state_in = S_DROP_RD;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            if (rsp_valid_ff && rsp.ready) begin
               rsp_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign hkey = key_ff;
   assign rsp.valid = rsp_valid_ff && (state_ff == S_DONE);
   assign rsp.status = status_ff;
   assign rsp.found_value = vout_ff;
   assign rsp.entry_count = cnt_ff;

   `RHH_ASSERT(a_busy_no_ready, clock, reset, (state_ff != S_IDLE) |-> !req.ready,
      "ready high while busy")
   `RHH_ASSERT(a_cnt_range, clock, reset, cnt_ff <= CNT_W'(SLOTS), "count above slot total")
   `RHH_ASSERT(a_rsp_only_done, clock, reset, rsp.valid |-> (state_ff == S_DONE),
      "response outside done state")
   `RHH_ASSERT(a_idle_hash_quiet, clock, reset, (state_ff == S_IDLE) |-> !hash_busy,
      "hash unit busy while idle")
endmodule

[src/robin_hood_hash_table_core.sv]
// Robin Hood hash table top level
// channel | dir | handshake     | payload
// req     | in  | valid/ready   | op, key, value
// rsp     | out | valid/ready   | status, found_value, entry_count
// csr     | in  | write enable  | csr_wdata (limit)
// A request is accepted and hashed (4 bytes, each XORed in and then multiplied
// through the shared 16-bit-slice multiplier, then the done flag), then probed
// slot by slot; an insert walks from the home slot, a remove shifts later
// entries back, and last the response is raised. Reset is synchronous, clears
// used marks and count and sets the limit to LIMIT_RESET at once; no clearing
// pass. Ready is low from acceptance until the response word is taken.
module robin_hood_hash_table_core (
   input  logic clock,
   input  logic reset,
   rhh_req_if.sink req,
   rhh_rsp_if.source rsp,
   input  logic csr_we,
   input  logic [6:0] csr_wdata
);
   import rhh_pkg::*;

   logic [6:0] limit_ff;
   hash_ctl_type hctl;
   key_type hkey, rd_key, wr_key;
   val_type rd_val, wr_val;
   idx_type home, rd_idx, rd_dist, wr_idx, wr_dist;
   logic rd_used, wr_en, wr_kv, wr_used, hash_busy, hash_done;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= LIMIT_RESET;
      else if (csr_we) limit_ff <= csr_wdata;
   end

   rhh_hash u_hash (.clock, .reset, .start(hctl.start), .key(hkey),
      .busy(hash_busy), .done(hash_done), .home);

   rhh_store u_store (.clock, .reset, .rd_idx, .rd_key, .rd_val, .rd_used,
      .rd_dist, .wr_en, .wr_idx, .wr_kv, .wr_key, .wr_val, .wr_used, .wr_dist);

   rhh_ctrl u_ctrl (.clock, .reset, .req, .rsp, .limit(limit_ff), .hctl, .hkey,
      .home, .rd_idx, .rd_key, .rd_val, .rd_used, .rd_dist, .wr_en, .wr_idx,
      .wr_kv, .wr_key, .wr_val, .wr_used, .wr_dist, .hash_busy, .hash_done);
endmodule
